// ===== design/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the scoped symbol stack
// Widths, operation and status codes, and the structs moved between modules.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int KEY_WIDTH   = 16;
    localparam int VALUE_WIDTH = 64;

    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LB_W   = 4;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_SET  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LGET = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [KEY_WIDTH-1:0]   key_id;
        logic [VALUE_WIDTH-1:0] item_value;
        logic [CNT_W-1:0]       restore_level;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]      status;
        logic [VALUE_WIDTH-1:0] found_value;
        logic [IDX_W-1:0]       position;
    } t_out;

    // Search token walking down the row of cells, top entry first
    typedef struct packed {
        logic                   vld;
        logic [KIND_W-1:0]      kind;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] val;
        logic [LB_W-1:0]        lb;
        logic                   done;
        logic                   hit;
        logic [IDX_W-1:0]       pos;
    } t_tok;

    // Direct write into one entry (append or scope marker)
    typedef struct packed {
        logic                   en;
        logic                   key_only;
        logic [IDX_W-1:0]       idx;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] val;
    } t_wr;

endpackage

// ===== design/sss_cell.sv =====
// ----------------------------------------------------------------------------
// sss_cell: one stack entry of the scoped symbol stack
// Holds a key and a value, tests the passing search token against them and
// hands the token on to the entry below.
// ----------------------------------------------------------------------------
module sss_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sss_pkg::IDX_W-1:0]        i_index,
    input  logic [sss_pkg::CNT_W-1:0]        i_count,
    input  sss_pkg::t_wr                     i_wr,
    input  sss_pkg::t_tok                    i_tok,
    output sss_pkg::t_tok                    o_tok
);

    logic [sss_pkg::KEY_WIDTH-1:0]   r_key;
    logic [sss_pkg::VALUE_WIDTH-1:0] r_val;
    sss_pkg::t_tok                   r_tok;
    sss_pkg::t_tok                   n_tok;
    logic                            w_live;
    logic                            w_set_hit;
    logic                            w_wr_sel;

    assign w_live   = {1'b0, i_index} < i_count;
    assign w_wr_sel = i_wr.en && (i_wr.idx == i_index);

    always_comb begin
        n_tok     = i_tok;
        w_set_hit = 1'b0;
        if (i_tok.vld && !i_tok.done && w_live) begin
            case (i_tok.kind)
                sss_pkg::KIND_SET: begin
                    if (i_tok.lb != '0) begin
                        if (r_key == '0) begin
                            // marker ends the lookback: append later
                            n_tok.done = 1'b1;
                        end else if (r_key == i_tok.key) begin
                            n_tok.done = 1'b1;
                            n_tok.hit  = 1'b1;
                            n_tok.pos  = i_index;
                            w_set_hit  = 1'b1;
                        end else begin
                            n_tok.lb = i_tok.lb - 1'b1;
                        end
                    end
                end
                sss_pkg::KIND_GET, sss_pkg::KIND_LGET: begin
                    if (r_key == '0) begin
                        if (i_tok.kind == sss_pkg::KIND_LGET) begin
                            n_tok.done = 1'b1;
                        end
                    end else if (r_key == i_tok.key) begin
                        n_tok.done = 1'b1;
                        n_tok.hit  = 1'b1;
                        n_tok.pos  = i_index;
                        n_tok.val  = r_val;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_key <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_wr_sel) begin
                r_key <= i_wr.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_sel && !i_wr.key_only) begin
            r_val <= i_wr.val;
        end else if (w_set_hit) begin
            r_val <= i_tok.val;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== design/sss_ctrl.sv =====
// ----------------------------------------------------------------------------
// sss_ctrl: command control of the scoped symbol stack
// Takes commands, launches search tokens into the cell row, keeps the entry
// count and the lookback register, and registers one result per command.
// ----------------------------------------------------------------------------
module sss_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sss_pkg::t_in                  i_item,
    input  logic                          i_cfg_we,
    input  logic [sss_pkg::LB_W-1:0]      i_cfg_wdata,
    output sss_pkg::t_tok                 o_tok,
    input  sss_pkg::t_tok                 i_tok,
    output sss_pkg::t_wr                  o_wr,
    output logic [sss_pkg::CNT_W-1:0]     o_count,
    output logic                          o_strobe,
    output sss_pkg::t_out                 o_result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                         r_state;
    logic                         n_state;
    logic [sss_pkg::CNT_W-1:0]    r_count;
    logic [sss_pkg::CNT_W-1:0]    n_count;
    logic [sss_pkg::LB_W-1:0]     r_lookback;
    logic                         r_strobe;
    logic                         n_strobe;
    sss_pkg::t_out                r_result;
    sss_pkg::t_out                n_result;
    logic                         w_accept;
    logic                         w_full;

    assign busy     = (r_state == ST_SCAN);
    assign w_accept = start && !busy;
    assign w_full   = r_count >= sss_pkg::CNT_W'(sss_pkg::STACK_DEPTH);

    always_comb begin
        o_tok.vld  = w_accept && (i_item.kind inside
                     {sss_pkg::KIND_SET, sss_pkg::KIND_GET, sss_pkg::KIND_LGET});
        o_tok.kind = i_item.kind;
        o_tok.key  = i_item.key_id;
        o_tok.val  = i_item.item_value;
        o_tok.lb   = r_lookback;
        o_tok.done = 1'b0;
        o_tok.hit  = 1'b0;
        o_tok.pos  = '0;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_strobe = 1'b0;
        n_result = '0;
        o_wr     = '0;
        o_wr.idx = r_count[sss_pkg::IDX_W-1:0];
        o_wr.key = i_item.key_id;
        o_wr.val = i_item.item_value;
        if (r_state == ST_SCAN) begin
            if (i_tok.vld) begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                if (i_tok.kind == sss_pkg::KIND_SET) begin
                    if (i_tok.hit) begin
                        n_result.position = i_tok.pos;
                    end else if (w_full) begin
                        n_result.status = sss_pkg::STAT_FULL;
                    end else begin
                        // no match in the lookback window: append on top
                        o_wr.en           = 1'b1;
                        o_wr.key          = i_tok.key;
                        o_wr.val          = i_tok.val;
                        n_result.position = r_count[sss_pkg::IDX_W-1:0];
                        n_count           = r_count + 1'b1;
                    end
                end else if (i_tok.hit) begin
                    n_result.found_value = i_tok.val;
                    n_result.position    = i_tok.pos;
                end else begin
                    n_result.status = sss_pkg::STAT_NOT_FOUND;
                end
            end
        end else if (w_accept) begin
            case (i_item.kind)
                sss_pkg::KIND_SET, sss_pkg::KIND_GET, sss_pkg::KIND_LGET: begin
                    n_state = ST_SCAN;
                end
                sss_pkg::KIND_PUSH: begin
                    n_strobe = 1'b1;
                    if (w_full) begin
                        n_result.status = sss_pkg::STAT_FULL;
                    end else begin
                        o_wr.en           = 1'b1;
                        o_wr.key_only     = 1'b1;
                        o_wr.key          = '0;
                        n_result.position = r_count[sss_pkg::IDX_W-1:0];
                        n_count           = r_count + 1'b1;
                    end
                end
                sss_pkg::KIND_POP: begin
                    n_strobe = 1'b1;
                    if (i_item.restore_level > sss_pkg::CNT_W'(sss_pkg::STACK_DEPTH)) begin
                        n_count = sss_pkg::CNT_W'(sss_pkg::STACK_DEPTH);
                    end else begin
                        n_count = i_item.restore_level;
                    end
                end
                default: begin
                    n_strobe = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= sss_pkg::CNT_W'(1);
            r_lookback <= sss_pkg::LB_W'(4);
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_lookback <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_count  = r_count;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== design/scoped_symbol_stack.sv =====
// ----------------------------------------------------------------------------
// scoped_symbol_stack: key/value stack with scope markers
// Set, get and local get launch a token that walks all 256 cells, one per
//   cycle; the result strobe is registered once it returns to the control,
//   and busy stays high while it walks. Push, pop and unknown kinds give their
//   result in the cycle after the transfer and allow a new command in every cycle.
// Synchronous reset leaves one entry (the base marker) and lookback 4.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module scoped_symbol_stack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sss_pkg::t_in                i_item,
    input  logic                        i_cfg_we,
    input  logic [sss_pkg::LB_W-1:0]    i_cfg_wdata,
    output logic                        o_strobe,
    output sss_pkg::t_out               o_result
);

    sss_pkg::t_tok               w_tok [0:sss_pkg::STACK_DEPTH];
    sss_pkg::t_wr                w_wr;
    logic [sss_pkg::CNT_W-1:0]   w_count;

    sss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_tok       (w_tok[sss_pkg::STACK_DEPTH]),
        .i_tok       (w_tok[0]),
        .o_wr        (w_wr),
        .o_count     (w_count),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // top cell takes the launched token; the bottom cell returns it
    for (genvar g = 0; g < sss_pkg::STACK_DEPTH; g++) begin : g_cell
        sss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (sss_pkg::IDX_W'(g)),
            .i_count (w_count),
            .i_wr    (w_wr),
            .i_tok   (w_tok[g+1]),
            .o_tok   (w_tok[g])
        );
    end

endmodule

// ===== design/sss_checker.sv =====
// ----------------------------------------------------------------------------
// sss_checker: port-level checks of the scoped symbol stack
// Watches command transfers, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module sss_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  sss_pkg::t_in    i_item,
    input  logic            o_strobe,
    input  sss_pkg::t_out   o_result
);

    logic w_xfer;
    logic w_scan_kind;

    assign w_xfer      = start && !busy;
    assign w_scan_kind = (i_item.kind == sss_pkg::KIND_SET) ||
                         (i_item.kind == sss_pkg::KIND_GET) ||
                         (i_item.kind == sss_pkg::KIND_LGET);

    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && w_scan_kind |=> busy && !o_strobe)
        else $error("search command did not raise busy");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && !w_scan_kind |=> o_strobe && !busy)
        else $error("immediate command gave no result next cycle");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobed while busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status != sss_pkg::STAT_OK) |->
            (o_result.found_value == '0) && (o_result.position == '0))
        else $error("failed command reported a value or position");

endmodule

bind scoped_symbol_stack sss_checker u_sss_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for scoped_symbol_stack
// Drives set, get, local get, push, pop and unknown-kind commands with random
// idle gaps, predicts every answer from a shadow copy of the stack and compares
// each strobed result field by field. Runs a short directed sequence, then
// random phases under several lookback settings, with stack-filling episodes.
// ----------------------------------------------------------------------------
module testbench;
    import sss_pkg::*;

    localparam int POOL_SIZE    = 10;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 80;
    localparam int DRAIN_CYCLES = 300;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    t_in                 i_item      = '0;
    logic                i_cfg_we    = 1'b0;
    logic [LB_W-1:0]     i_cfg_wdata = '0;
    logic                o_strobe;
    t_out                o_result;

    scoped_symbol_stack dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // Shadow copy of the symbol stack
    logic [KEY_WIDTH-1:0]   shadow_keys [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] shadow_vals [STACK_DEPTH];
    int                     shadow_count    = 1;
    int                     shadow_written  = 1;
    int                     shadow_lookback = 4;

    t_in                    queued_cmds [$];
    t_out                   awaited_answers [$];
    int                     scope_marks [$];
    logic [KEY_WIDTH-1:0]   key_pool [POOL_SIZE];
    int                     error_count = 0;
    int                     idle_left   = 0;
    int                     calm_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("** scoped_symbol_stack: FAILED **");
        $finish;
    end

    task automatic report_mismatch(string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Work out the answer to one command and update the shadow stack
    function automatic t_out answer_for(t_in cmd);
        t_out ans;
        int   idx;
        bit   hit;
        ans = '0;
        hit = 1'b0;
        idx = 0;
        case (cmd.kind)
            KIND_SET: begin
                for (int i = 0; i < shadow_lookback && i < shadow_count; i++) begin
                    idx = shadow_count - 1 - i;
                    if (shadow_keys[idx] == '0) break;
                    if (shadow_keys[idx] == cmd.key_id) begin
                        hit = 1'b1;
                        break;
                    end
                end
                if (hit) begin
                    shadow_vals[idx] = cmd.item_value;
                    ans.position = IDX_W'(idx);
                end else if (shadow_count >= STACK_DEPTH) begin
                    ans.status = STAT_FULL;
                end else begin
                    shadow_keys[shadow_count] = cmd.key_id;
                    shadow_vals[shadow_count] = cmd.item_value;
                    ans.position = IDX_W'(shadow_count);
                    shadow_count++;
                    if (shadow_count > shadow_written) shadow_written = shadow_count;
                end
            end
            KIND_GET, KIND_LGET: begin
                if (cmd.key_id != '0) begin
                    for (int i = shadow_count - 1; i >= 0; i--) begin
                        if (shadow_keys[i] == '0) begin
                            // a local search ends at the scope marker
                            if (cmd.kind == KIND_LGET) break;
                        end else if (shadow_keys[i] == cmd.key_id) begin
                            hit = 1'b1;
                            idx = i;
                            break;
                        end
                    end
                end
                if (hit) begin
                    ans.found_value = shadow_vals[idx];
                    ans.position    = IDX_W'(idx);
                end else begin
                    ans.status = STAT_NOT_FOUND;
                end
            end
            KIND_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    ans.status = STAT_FULL;
                end else begin
                    shadow_keys[shadow_count] = '0;
                    ans.position = IDX_W'(shadow_count);
                    shadow_count++;
                    if (shadow_count > shadow_written) shadow_written = shadow_count;
                end
            end
            KIND_POP: begin
                shadow_count = (int'(cmd.restore_level) > STACK_DEPTH) ?
                               STACK_DEPTH : int'(cmd.restore_level);
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic send_cmd(logic [KIND_W-1:0] kind, logic [KEY_WIDTH-1:0] key,
                            logic [VALUE_WIDTH-1:0] value, logic [CNT_W-1:0] level);
        t_in cmd;
        cmd.kind          = kind;
        cmd.key_id        = key;
        cmd.item_value    = value;
        cmd.restore_level = level;
        queued_cmds.push_back(cmd);
        awaited_answers.push_back(answer_for(cmd));
    endtask

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 15) return KEY_WIDTH'($urandom_range(1, 65535));
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Only levels over entries already written; beyond the depth once it was full
    function automatic logic [CNT_W-1:0] any_pop_level();
        if (shadow_written >= STACK_DEPTH && $urandom_range(0, 3) == 0) begin
            return CNT_W'($urandom_range(STACK_DEPTH, 2**CNT_W - 1));
        end
        return CNT_W'($urandom_range(0, shadow_written));
    endfunction

    task automatic drop_stale_marks();
        while (scope_marks.size() > 0 && scope_marks[$] > shadow_count) begin
            void'(scope_marks.pop_back());
        end
    endtask

    task automatic wait_for_answers();
        while (queued_cmds.size() != 0 || start || awaited_answers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: present the next command, hold it until the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (idle_left > 0) begin
                start <= 1'b0;
                idle_left--;
            end else if (queued_cmds.size() > 0) begin
                i_item <= queued_cmds.pop_front();
                start  <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                    idle_left = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    calm_left = $urandom_range(5, 40);
                    idle_left = 0;
                end else begin
                    idle_left = $urandom_range(0, 19);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (awaited_answers.size() == 0) begin
                report_mismatch($sformatf("result with nothing awaited: %h", o_result));
            end else begin
                want = awaited_answers.pop_front();
                if (o_result.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_result.status, want.status));
                end
                if (o_result.found_value !== want.found_value) begin
                    report_mismatch($sformatf("found_value %h, want %h",
                                              o_result.found_value, want.found_value));
                end
                if (o_result.position !== want.position) begin
                    report_mismatch($sformatf("position %0d, want %0d",
                                              o_result.position, want.position));
                end
            end
        end
    end

    initial begin
        int unsigned      roll;
        int               lb;
        int               base;
        logic [CNT_W-1:0] level;

        shadow_keys[0] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty lookups, overwrite, scopes, key 0, odd kinds, empty stack
        send_cmd(KIND_GET,  16'd1,    '0, '0);
        send_cmd(KIND_LGET, 16'hFFFF, '0, '0);
        send_cmd(KIND_GET,  '0,       '0, '0);
        send_cmd(KIND_SET,  16'hFFFF, '1, '0);
        send_cmd(KIND_SET,  16'd1,    '0, '1);
        send_cmd(KIND_SET,  16'hFFFF, 64'h5555_5555_5555_5555, '0);
        send_cmd(KIND_GET,  16'hFFFF, '0, '0);
        send_cmd(KIND_PUSH, '0,       '1, '1);
        send_cmd(KIND_LGET, 16'd1,    '0, '0);
        send_cmd(KIND_GET,  16'd1,    '0, '0);
        send_cmd(KIND_SET,  '0,       64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_cmd(KIND_SET,  16'd1,    {$urandom, $urandom}, '0);
        send_cmd(KIND_LGET, 16'd1,    '0, '0);
        for (int k = 5; k < 8; k++) begin
            send_cmd(KIND_W'(k), '1, '1, '1);
        end
        send_cmd(KIND_POP,  '0,       '0, '0);
        send_cmd(KIND_GET,  16'd1,    '0, '0);
        send_cmd(KIND_LGET, 16'd1,    '0, '0);
        send_cmd(KIND_PUSH, '0,       '0, '0);
        send_cmd(KIND_POP,  '0,       '0, CNT_W'(6));
        send_cmd(KIND_GET,  16'd1,    '0, '0);
        send_cmd(KIND_POP,  '0,       '0, CNT_W'(1));

        for (int p = 0; p < PHASES; p++) begin
            wait_for_answers();
            repeat (4) @(posedge i_clk);
            case (p)
                0:       lb = 1;
                1:       lb = 8;
                2:       lb = 0;
                3:       lb = 15;
                default: lb = $urandom_range(0, 15);
            endcase
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= LB_W'(lb);
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            shadow_lookback = lb;

            foreach (key_pool[k]) begin
                key_pool[k] = KEY_WIDTH'($urandom_range(1, 65535));
            end

            // Fill the stack to the top, probe it while full, then restore
            if (p % 3 == 0) begin
                base = shadow_count;
                while (shadow_count < STACK_DEPTH) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_cmd(KIND_SET, pick_key(), {$urandom, $urandom}, '0);
                    end else begin
                        send_cmd(KIND_PUSH, '0, '0, '0);
                    end
                end
                send_cmd(KIND_SET, KEY_WIDTH'($urandom_range(1, 65535)),
                         {$urandom, $urandom}, '0);
                send_cmd(KIND_PUSH, '0, '0, '0);
                send_cmd(KIND_GET,  pick_key(), '0, '0);
                send_cmd(KIND_LGET, pick_key(), '0, '0);
                send_cmd(KIND_POP, '0, '0,
                         CNT_W'($urandom_range(STACK_DEPTH, 2**CNT_W - 1)));
                send_cmd(KIND_PUSH, '0, '0, '0);
                send_cmd(KIND_POP, '0, '0, CNT_W'(base));
                drop_stale_marks();
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                // steer back down once the stack runs high
                if (shadow_count > 192 && roll < 60) roll = 85;
                if (roll < 35) begin
                    send_cmd(KIND_SET, pick_key(), {$urandom, $urandom}, CNT_W'($urandom));
                end else if (roll < 55) begin
                    send_cmd(KIND_GET, pick_key(), {$urandom, $urandom}, CNT_W'($urandom));
                end else if (roll < 70) begin
                    send_cmd(KIND_LGET, pick_key(), {$urandom, $urandom}, CNT_W'($urandom));
                end else if (roll < 80) begin
                    if (shadow_count < STACK_DEPTH) scope_marks.push_back(shadow_count);
                    send_cmd(KIND_PUSH, KEY_WIDTH'($urandom), {$urandom, $urandom},
                             CNT_W'($urandom));
                end else if (roll < 92) begin
                    if (scope_marks.size() > 0) begin
                        level = CNT_W'(scope_marks.pop_back());
                    end else begin
                        level = any_pop_level();
                    end
                    send_cmd(KIND_POP, KEY_WIDTH'($urandom), {$urandom, $urandom}, level);
                    drop_stale_marks();
                end else if (roll < 96) begin
                    send_cmd(KIND_POP, KEY_WIDTH'($urandom), {$urandom, $urandom},
                             any_pop_level());
                    drop_stale_marks();
                end else begin
                    send_cmd(KIND_W'($urandom_range(5, 7)), KEY_WIDTH'($urandom),
                             {$urandom, $urandom}, CNT_W'($urandom));
                end
            end
        end

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_answers.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_answers.size()));
        end
        if (error_count == 0) begin
            $display("** scoped_symbol_stack: PASSED **");
        end else begin
            $display("** scoped_symbol_stack: FAILED **");
        end
        $finish;
    end

endmodule

// ===== scoped_symbol_stack.f =====
design/sss_pkg.sv
design/sss_cell.sv
design/sss_ctrl.sv
design/scoped_symbol_stack.sv
design/sss_checker.sv
tb/testbench.sv
